// File: sv/mfps_pkg.sv
// Shared constants for the minimum falling path sum block.
`default_nettype none

package mfps_pkg;

    // Path sums are held and reported as 23-bit two's complement values.
    localparam int SUM_BITS = 23;

    // Result bus width, padded up to whole bytes.
    localparam int OUT_W = ((SUM_BITS + 7) / 8) * 8;

    // Largest representable path sum; also the start value of the running minimum.
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};

    // Smallest representable path sum.
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // Grid side register width and value after reset.
    localparam int GRID_BITS  = 8;
    localparam int GRID_RESET = 128;

endpackage

`default_nettype wire

// File: sv/min_falling_path_sum.sv
// Top level of the minimum falling path sum block.
//
// Usage:
//   Write the grid side on cfg_wr_en / cfg_wr_data while the block is idle; a write
//   restarts the grid. A side of zero acts as one, a side above MAX_SIZE as MAX_SIZE.
//   Cells enter on the s_ stream in row-major order, one signed cost per request.
//   After the final cell of a grid one request leaves on the m_ stream carrying the
//   least top-to-bottom falling path sum; the next cell then starts a new grid.
// Flow:
//   One cell is taken every cycle while s_tready is high. A grid's final cell is
//   registered in the update stage, its result in the output register behind m_tvalid.
//   The row buffer is a memory with one read port and registered read data: each cell
//   reads the up-right sum as it is accepted and writes its own sum back from the update stage.
// Reset and stalls:
//   Reset sets the side to 128, or MAX_SIZE if smaller, and starts a new grid; the
//   row buffer needs no clearing, since a grid reads only entries it has written itself.
//   While a result waits on m_tready, cells keep flowing; only the final cell of
//   the following grid is held, and s_tready drops until the result is taken.
`default_nettype none

module min_falling_path_sum #(
    parameter int MAX_SIZE   = 128,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration: grid side.
    input  wire logic                                cfg_wr_en,
    input  wire logic [mfps_pkg::GRID_BITS-1:0]      cfg_wr_data,
    // Cell stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // [VALUE_BITS-1:0] cell_value
    // Result stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mfps_pkg::OUT_W-1:0]               m_tdata   // [22:0] min_path_sum
);

    localparam int SB   = mfps_pkg::SUM_BITS;
    localparam int GB   = mfps_pkg::GRID_BITS;
    localparam int AW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CMPW = ((AW > GB) ? AW : GB) + 1;
    localparam int EW   = ((VALUE_BITS > SB) ? VALUE_BITS : SB) + 1;
    localparam logic [GB-1:0] SIDE_RESET =
        GB'((mfps_pkg::GRID_RESET > MAX_SIZE) ? MAX_SIZE : mfps_pkg::GRID_RESET);

    localparam logic signed [EW-1:0] SAT_HI =
        {{(EW-SB){mfps_pkg::SUM_MAX[SB-1]}}, mfps_pkg::SUM_MAX};
    localparam logic signed [EW-1:0] SAT_LO =
        {{(EW-SB){mfps_pkg::SUM_MIN[SB-1]}}, mfps_pkg::SUM_MIN};

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic has_right;
        logic last_cell;
    } cell_flags_t;

    // Configuration and position state.
    logic [GB-1:0]          side_reg;
    logic [AW-1:0]          col_reg;
    logic [AW-1:0]          row_reg;

    // Update stage.
    logic                   s1_valid_reg;
    logic [VALUE_BITS-1:0]  s1_value_reg;
    logic [AW-1:0]          s1_col_reg;
    cell_flags_t            s1_flags_reg;

    // Window over the previous row and bypass of a same-entry write.
    logic signed [SB-1:0]   up_reg;
    logic signed [SB-1:0]   left_reg;
    logic signed [SB-1:0]   first_reg;
    logic                   fwd_hit_reg;
    logic signed [SB-1:0]   fwd_data_reg;
    logic signed [SB-1:0]   rd_data;

    logic signed [SB-1:0]   best_reg;
    logic                   m_valid_reg;
    logic signed [SB-1:0]   m_data_reg;

    logic                   accept;
    logic                   s1_adv;
    logic                   s1_fire;
    logic [CMPW-1:0]        col_plus;
    logic [CMPW-1:0]        row_plus;
    logic [CMPW-1:0]        side_ext;
    logic                   last_col;
    logic                   last_row;
    cell_flags_t            flags_in;
    logic [AW-1:0]          rd_addr;
    logic signed [SB-1:0]   up_eff;
    logic signed [SB-1:0]   right_eff;
    logic signed [SB-1:0]   least;
    logic signed [EW-1:0]   sum_wide;
    logic signed [SB-1:0]   sum;
    logic signed [SB-1:0]   best_with_sum;
    logic [GB-1:0]          side_next;

    // Handshake: the update stage is held only when it carries a result and the
    // output register is still occupied.
    assign s1_adv   = !(s1_flags_reg.last_cell && m_valid_reg && !m_tready);
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Position decode for the incoming cell.
    assign col_plus = CMPW'(col_reg) + CMPW'(1);
    assign row_plus = CMPW'(row_reg) + CMPW'(1);
    assign side_ext = CMPW'(side_reg);
    assign last_col = (col_plus >= side_ext);
    assign last_row = (row_plus >= side_ext);

    always_comb begin
        flags_in.first_row = (row_reg == '0);
        flags_in.last_row  = last_row;
        flags_in.has_right = !last_col;
        flags_in.last_cell = last_col && last_row;
    end

    // The up-right neighbor is fetched as the cell is accepted.
    assign rd_addr = AW'(col_plus);

    mfps_row_ram #(
        .DEPTH (MAX_SIZE),
        .WIDTH (SB)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (sum),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Neighbor selection and the new path sum.
    assign up_eff    = (s1_col_reg == '0) ? first_reg : up_reg;
    assign right_eff = fwd_hit_reg ? fwd_data_reg : rd_data;

    always_comb begin
        least = up_eff;
        if ((s1_col_reg != '0) && (left_reg < least)) begin
            least = left_reg;
        end
        if (s1_flags_reg.has_right && (right_eff < least)) begin
            least = right_eff;
        end
        if (s1_flags_reg.first_row) begin
            sum_wide = EW'($signed(s1_value_reg));
        end else begin
            sum_wide = EW'($signed(s1_value_reg)) + EW'(least);
        end
        if (sum_wide > SAT_HI) begin
            sum = mfps_pkg::SUM_MAX;
        end else if (sum_wide < SAT_LO) begin
            sum = mfps_pkg::SUM_MIN;
        end else begin
            sum = SB'(sum_wide);
        end
        best_with_sum = (sum < best_reg) ? sum : best_reg;
    end

    // Side as written, with zero and oversize values folded into range.
    always_comb begin
        if (cfg_wr_data == '0) begin
            side_next = GB'(1);
        end else if (int'(cfg_wr_data) > MAX_SIZE) begin
            side_next = GB'(MAX_SIZE);
        end else begin
            side_next = cfg_wr_data;
        end
    end

    // Control state: side, position, stage valid, running minimum and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg     <= SIDE_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            best_reg     <= mfps_pkg::SUM_MAX;
            m_valid_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            side_reg     <= side_next;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            best_reg     <= mfps_pkg::SUM_MAX;
        end else begin
            if (accept) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : AW'(row_plus);
                end else begin
                    col_reg <= AW'(col_plus);
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                if (s1_flags_reg.last_cell) begin
                    best_reg <= mfps_pkg::SUM_MAX;
                end else if (s1_flags_reg.last_row) begin
                    best_reg <= best_with_sum;
                end
            end
            if (s1_fire && s1_flags_reg.last_cell) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the update stage and the bypass for a read of the entry being written.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg <= s_tdata[VALUE_BITS-1:0];
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags_in;
            fwd_hit_reg  <= s1_fire && (s1_col_reg == rd_addr);
            fwd_data_reg <= sum;
        end
    end

    // Window shift over the previous row as each cell completes.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            left_reg <= up_eff;
            up_reg   <= right_eff;
            if (s1_col_reg == '0) begin
                first_reg <= sum;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (s1_fire && s1_flags_reg.last_cell) begin
            m_data_reg <= best_with_sum;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mfps_pkg::OUT_W-SB){1'b0}}, m_data_reg};

endmodule

`default_nettype wire

// File: sv/mfps_row_ram.sv
// Single-port-write, single-port-read row buffer with registered read data.
`default_nettype none

module mfps_row_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 23,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; old data is returned when the same entry is written in that cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/min_falling_path_sum_chk.sv
// Port-level checks for the minimum falling path sum block, bound to its top level.
`default_nettype none

module min_falling_path_sum_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_wr_en,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mfps_pkg::OUT_W-1:0]    m_tdata
);

    // A pending result holds its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A new result must be preceded by an accepted cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a final cell two cycles earlier");

    // With the output register empty, cells are always taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !cfg_wr_en |-> s_tready)
        else $error("input stalled with no result pending");

    // Padding bits of the result bus stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[mfps_pkg::OUT_W-1:mfps_pkg::SUM_BITS] == '0))
        else $error("result padding not zero");

endmodule

bind min_falling_path_sum min_falling_path_sum_chk u_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire
